### hdl/slm_pkg.sv
package slm_pkg;

   localparam int DEPTH_DEFAULT       = 32;
   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int ELEM_W              = 32;

   localparam logic OP_LIST_A = 1'b0;
   localparam logic OP_LIST_B = 1'b1;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_FETCH,
      ST_MERGE
   } state_type;

endpackage

### hdl/sorted_list_merge_core.sv
// channel | ports  | tdata             | tuser          | tlast
// --------+--------+-------------------+----------------+------------
// input   | req_*  | element [31:0]    | opcode (0 = A) | end_of_load
// result  | rsp_*  | merged_value      | overflow       | last_result
//
// Loading takes one item per cycle; req_tready is high while no merge runs.
// The item with end_of_load is followed by ST_FETCH for the RAMs' registered
// read, then one result per unstalled cycle, set by the single compare unit.
// A stalled rsp_tready holds the result register and pauses the merge.
// Synchronous reset empties both lists and drops any pending result item.
// List RAMs need no clearing pass: only entries below the counts are used.
module sorted_list_merge_core
   import slm_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [ELEM_W-1:0] req_tdata,   // [31:0] element
   input  logic              req_tuser,   // [0] opcode
   input  logic              req_tlast,   // end_of_load
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [ELEM_W-1:0] rsp_tdata,   // [31:0] merged_value
   output logic              rsp_tuser,   // [0] overflow
   output logic              rsp_tlast    // last_result
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0] ia_ff, ia_in, ib_ff, ib_in;
   logic [CNT_W-1:0] na, nb;
   logic             drop_ff, drop_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic [VALUE_WIDTH-1:0] elem_wide, head_a, head_b;
   logic accept, wr_a, wr_b, have_a, have_b, take_a, slot_free;

   generate
      if (VALUE_WIDTH > ELEM_W) begin : g_widen
         assign elem_wide = {{(VALUE_WIDTH - ELEM_W){req_tdata[ELEM_W-1]}}, req_tdata};
         assign rsp_tdata = rsp_value_ff[ELEM_W-1:0];
      end else if (VALUE_WIDTH == ELEM_W) begin : g_same
         assign elem_wide = req_tdata;
         assign rsp_tdata = rsp_value_ff;
      end else begin : g_narrow
         assign elem_wide = req_tdata[VALUE_WIDTH-1:0];
         assign rsp_tdata = {{(ELEM_W - VALUE_WIDTH){1'b0}}, rsp_value_ff};
      end
   endgenerate

   assign accept = req_tvalid && req_tready;
   assign wr_a   = accept && (req_tuser == OP_LIST_A) && (cnt_a_ff < CNT_W'(DEPTH));
   assign wr_b   = accept && (req_tuser == OP_LIST_B) && (cnt_b_ff < CNT_W'(DEPTH));

   slm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (cnt_a_ff[IDX_W-1:0]),
      .wr_data (elem_wide),
      .rd_addr (ia_in[IDX_W-1:0]),
      .rd_data (head_a)
   );

   slm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (cnt_b_ff[IDX_W-1:0]),
      .wr_data (elem_wide),
      .rd_addr (ib_in[IDX_W-1:0]),
      .rd_data (head_b)
   );

   assign have_a    = ia_ff < cnt_a_ff;
   assign have_b    = ib_ff < cnt_b_ff;
   assign take_a    = have_a && (!have_b || ($signed(head_a) < $signed(head_b)));
   assign na        = take_a ? ia_ff + CNT_W'(1) : ia_ff;
   assign nb        = take_a ? ib_ff : ib_ff + CNT_W'(1);
   assign slot_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         ia_ff        <= ia_in;
         ib_ff        <= ib_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (wr_a) begin
                  cnt_a_in = cnt_a_ff + CNT_W'(1);
               end else if (wr_b) begin
                  cnt_b_in = cnt_b_ff + CNT_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (slot_free) begin
               if (!have_a && !have_b) begin
                  cnt_a_in = '0;
                  cnt_b_in = '0;
                  ia_in    = '0;
                  ib_in    = '0;
                  drop_in  = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = take_a ? head_a : head_b;
                  rsp_ovf_in   = drop_ff;
                  rsp_last_in  = (na == cnt_a_ff) && (nb == cnt_b_ff);
                  ia_in        = na;
                  ib_in        = nb;
                  if ((na == cnt_a_ff) && (nb == cnt_b_ff)) begin
                     cnt_a_in = '0;
                     cnt_b_in = '0;
                     ia_in    = '0;
                     ib_in    = '0;
                     drop_in  = 1'b0;
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

### hdl/slm_ram.sv
module slm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/slm_checker.sv
module slm_checker
   import slm_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              req_tlast,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [ELEM_W-1:0] rsp_tdata,
   input logic              rsp_tuser,
   input logic              rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   a_busy_after_end: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input taken right after end of load");

   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken before the merge run ended");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind sorted_list_merge_core slm_checker u_slm_checker (.*);
